// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers included by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ptrs_pkg.sv =====
package ptrs_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int RESULT_CAP     = 8;
    localparam int EMIT_W         = 4;
    localparam int TICK_W         = 8;
    localparam int PERIOD_W       = 16;
    localparam int STEP_W         = 3;
    localparam logic [7:0] OPT_RESET = 8'd4;

    typedef enum logic [1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_CHK,
        S_REPLY,
        S_TCK_RD,
        S_TCK_MOD,
        S_TCK_WAIT,
        S_SEL_RD,
        S_SEL_CHK,
        S_EMIT
    } t_state;

    // One task table entry, valid bit kept apart in flops
    typedef struct packed {
        logic [7:0]          prio;
        logic [PERIOD_W-1:0] period;
        logic [7:0]          handle;
    } t_entry;

    // Result of the divisibility check
    typedef struct packed {
        logic done;
        logic divides;
    } t_mod_res;

endpackage

// ===== hw/rtl/ptrs_mod_unit.sv =====
module ptrs_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ptrs_pkg::TICK_W-1:0]   i_dividend,
    input  logic [ptrs_pkg::PERIOD_W-1:0] i_divisor,
    output ptrs_pkg::t_mod_res            o_res
);
    import ptrs_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [TICK_W-1:0]   r_dvd;
    logic [PERIOD_W-1:0] r_div;
    logic [TICK_W-1:0]   r_rem;

    logic [TICK_W:0]     w_trial;
    logic                w_ge;
    logic [PERIOD_W-1:0] w_diff;

    // Restoring remainder step: one dividend bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[TICK_W-1]};
        w_ge    = {{(PERIOD_W-TICK_W-1){1'b0}}, w_trial} >= r_div;
        w_diff  = {{(PERIOD_W-TICK_W-1){1'b0}}, w_trial} - r_div;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(TICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[TICK_W-1:0] : w_trial[TICK_W-1:0];
        end
    end

    assign o_res.done    = r_done;
    assign o_res.divides = (r_rem == '0);

endmodule

// ===== hw/rtl/periodic_task_release_scheduler_unit.sv =====
// Periodic task release scheduler. Items on the slave stream carry a function code in
// tuser (create, delete, timer overflow). Create and delete return one status item.
// A timer overflow advances the prescaler; on a tick the 8-bit tick count advances and
// every valid task whose nonzero period divides it is released, lowest priority first,
// ties to the lower slot, at most 8 per tick, the final one marked with tlast. One item
// is processed at a time through a single-port task memory. A create goes straight to
// its reply; a delete reads and checks each slot, then replies; an overflow without a
// tick returns to idle; a tick reads each slot through the remainder unit, then makes
// one selection pass over all slots per release, held by any output stall. No clearing pass after reset.
module periodic_task_release_scheduler_unit #(
    parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,      // overflows_per_tick
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // task_handle[7:0], period[23:8], priority_req[31:24]
    input  logic [1:0]  s_axis_tuser,     // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,     // released_handle[7:0], status[9:8], zero[15:10]
    output logic [0:0]  m_axis_tuser,     // kind[0]
    output logic        m_axis_tlast
);
    import ptrs_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    t_state              r_state, n_state;
    t_entry              r_mem [TASK_SLOTS];
    t_entry              r_rd;
    logic [TASK_SLOTS-1:0] r_valid;
    logic [TASK_SLOTS-1:0] r_due;
    logic [CW-1:0]       r_next_slot;
    logic [CW-1:0]       r_due_cnt;
    logic [IW-1:0]       r_idx;
    logic [EMIT_W-1:0]   r_emit;
    logic [7:0]          r_opt;
    logic [7:0]          r_ovf;
    logic [TICK_W-1:0]   r_tick;
    logic [7:0]          r_hd;
    logic                r_found;
    logic [IW-1:0]       r_best;
    logic                r_best_ok;
    logic [7:0]          r_best_prio;
    logic [7:0]          r_best_hd;
    t_status             r_reply;

    logic                r_m_valid;
    logic                r_m_kind;
    logic [7:0]          r_m_handle;
    t_status             r_m_status;
    logic                r_m_last;

    t_func               w_func;
    logic                w_accept;
    logic                w_out_free;
    logic                w_idx_last;
    logic [7:0]          w_ovf_inc;
    logic                w_tick;
    logic                w_due_now;
    logic                w_match;
    logic                w_better;
    logic [7:0]          w_cnt_w;
    logic [EMIT_W-1:0]   w_total;
    logic                w_rel_last;
    logic                w_rd_en;
    logic                w_mod_start;
    logic                w_load_reply;
    logic                w_load_rel;
    t_mod_res            w_mod;

    ptrs_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_tick),
        .i_divisor  (r_rd.period),
        .o_res      (w_mod)
    );

    // Decode and status terms
    always_comb begin
        w_func     = t_func'(s_axis_tuser);
        w_accept   = s_axis_tvalid && s_axis_tready;
        w_out_free = !r_m_valid || m_axis_tready;
        w_idx_last = (r_idx == IW'(TASK_SLOTS - 1));
        w_ovf_inc  = r_ovf + 8'd1;
        w_tick     = !(w_ovf_inc < r_opt);
        w_due_now  = r_valid[r_idx] && (r_rd.period != '0) && w_mod.divides;
        w_match    = r_valid[r_idx] && (r_rd.handle == r_hd);
        w_better   = r_due[r_idx] && (!r_best_ok || (r_rd.prio < r_best_prio));
        w_cnt_w    = 8'(r_due_cnt);
        w_total    = (w_cnt_w >= 8'(RESULT_CAP)) ? EMIT_W'(RESULT_CAP) : w_cnt_w[EMIT_W-1:0];
        w_rel_last = (r_emit == (w_total - EMIT_W'(1)));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_func)
                        FUNC_CREATE: n_state = S_REPLY;
                        FUNC_DELETE: n_state = S_DEL_RD;
                        FUNC_TICK:   n_state = w_tick ? S_TCK_RD : S_IDLE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_DEL_RD:   n_state = S_DEL_CHK;
            S_DEL_CHK:  n_state = w_idx_last ? S_REPLY : S_DEL_RD;
            S_REPLY:    n_state = w_out_free ? S_IDLE : S_REPLY;
            S_TCK_RD:   n_state = S_TCK_MOD;
            S_TCK_MOD:  n_state = S_TCK_WAIT;
            S_TCK_WAIT: begin
                if (w_mod.done) begin
                    if (!w_idx_last) begin
                        n_state = S_TCK_RD;
                    end else if (r_due_cnt == '0 && !w_due_now) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SEL_RD;
                    end
                end
            end
            S_SEL_RD:   n_state = S_SEL_CHK;
            S_SEL_CHK:  n_state = w_idx_last ? S_EMIT : S_SEL_RD;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = w_rel_last ? S_IDLE : S_SEL_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_mod_start   = 1'b0;
        w_load_reply  = 1'b0;
        w_load_rel    = 1'b0;
        unique case (r_state)
            S_IDLE:    s_axis_tready = 1'b1;
            S_DEL_RD,
            S_TCK_RD,
            S_SEL_RD:  w_rd_en = 1'b1;
            S_TCK_MOD: w_mod_start = 1'b1;
            S_REPLY:   w_load_reply = w_out_free;
            S_EMIT:    w_load_rel = w_out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Task memory: write on create, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_func == FUNC_CREATE && r_next_slot < CW'(TASK_SLOTS)) begin
            r_mem[r_next_slot[IW-1:0]] <= t_entry'{prio:   s_axis_tdata[31:24],
                                                   period: s_axis_tdata[23:8],
                                                   handle: s_axis_tdata[7:0]};
        end
        if (w_rd_en) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_due       <= '0;
            r_next_slot <= '0;
            r_ovf       <= '0;
            r_tick      <= '0;
            r_opt       <= OPT_RESET;
            r_idx       <= '0;
            r_due_cnt   <= '0;
            r_emit      <= '0;
            r_found     <= 1'b0;
            r_best_ok   <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_opt <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept) begin
                        case (w_func)
                            FUNC_CREATE: begin
                                if (r_next_slot < CW'(TASK_SLOTS)) begin
                                    r_valid[r_next_slot[IW-1:0]] <= 1'b1;
                                    r_next_slot <= r_next_slot + CW'(1);
                                end
                            end
                            FUNC_DELETE: r_found <= 1'b0;
                            FUNC_TICK: begin
                                if (w_tick) begin
                                    r_ovf     <= '0;
                                    r_tick    <= r_tick + TICK_W'(1);
                                    r_due_cnt <= '0;
                                    r_emit    <= '0;
                                    r_due     <= '0;
                                end else begin
                                    r_ovf <= w_ovf_inc;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DEL_CHK: begin
                    if (w_match) begin
                        r_valid[r_idx] <= 1'b0;
                        r_found        <= 1'b1;
                    end
                    r_idx <= w_idx_last ? '0 : r_idx + IW'(1);
                end
                S_TCK_WAIT: begin
                    if (w_mod.done) begin
                        r_due[r_idx] <= w_due_now;
                        r_due_cnt    <= r_due_cnt + CW'(w_due_now);
                        r_idx        <= w_idx_last ? '0 : r_idx + IW'(1);
                        r_best_ok    <= 1'b0;
                    end
                end
                S_SEL_CHK: begin
                    if (w_better) begin
                        r_best_ok <= 1'b1;
                    end
                    r_idx <= w_idx_last ? '0 : r_idx + IW'(1);
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_due[r_best] <= 1'b0;
                        r_emit        <= r_emit + EMIT_W'(1);
                        r_best_ok     <= 1'b0;
                        r_idx         <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Held payload for the current item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hd    <= s_axis_tdata[7:0];
            r_reply <= (r_next_slot < CW'(TASK_SLOTS)) ? ST_DONE : ST_FULL;
        end
        if (r_state == S_DEL_CHK && w_idx_last) begin
            r_reply <= (r_found || w_match) ? ST_DONE : ST_NOT_FOUND;
        end
        if (r_state == S_SEL_CHK && w_better) begin
            r_best      <= r_idx;
            r_best_prio <= r_rd.prio;
            r_best_hd   <= r_rd.handle;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_load_reply || w_load_rel) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_reply) begin
            r_m_kind   <= KIND_STATUS;
            r_m_handle <= '0;
            r_m_status <= r_reply;
            r_m_last   <= 1'b1;
        end else if (w_load_rel) begin
            r_m_kind   <= KIND_RELEASE;
            r_m_handle <= r_best_hd;
            r_m_status <= ST_DONE;
            r_m_last   <= w_rel_last;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = {6'b0, r_m_status, r_m_handle};
    assign m_axis_tuser[0] = r_m_kind;
    assign m_axis_tlast    = r_m_last;

    `include "assert_macros.svh"

    `PTRS_ASSERT(a_slot_bound, r_next_slot <= CW'(TASK_SLOTS), "slot counter past table size")
    `PTRS_ASSERT(a_emit_bound, r_emit <= EMIT_W'(RESULT_CAP), "too many releases in one tick")
    `PTRS_ASSERT(a_create_adv, (w_accept && w_func == FUNC_CREATE && r_next_slot < CW'(TASK_SLOTS)) |=> (r_next_slot == $past(r_next_slot) + CW'(1)), "create did not advance slot")
    `PTRS_ASSERT(a_emit_has_best, (r_state == S_EMIT) |-> r_best_ok, "release with no selected task")

endmodule

// ===== tb/periodic_task_release_scheduler_unit_test.sv =====
module periodic_task_release_scheduler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptrs_pkg::*;

    localparam int SLOTS      = 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_LEN  = 400;

    typedef struct {
        logic       kind;
        logic [7:0] handle;
        logic [1:0] status;
        logic       last;
    } release_t;

    typedef struct {
        t_func       f;
        logic [7:0]  hd;
        logic [15:0] per;
        logic [7:0]  pr;
        bit          typed;
        t_status     st;
    } cmd_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wen = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // task_handle[7:0], period[23:8], priority_req[31:24]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // released_handle[7:0], status[9:8], zero[15:10]
    logic [0:0]  m_axis_tuser;        // kind[0]
    logic        m_axis_tlast;

    periodic_task_release_scheduler_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Scheduler shadow state
    bit          tbl_valid [SLOTS];
    logic [7:0]  tbl_handle[SLOTS];
    logic [15:0] tbl_period[SLOTS];
    logic [7:0]  tbl_prio  [SLOTS];
    int          fill_ptr;
    logic [7:0]  ovf_cnt;
    logic [7:0]  tick_cnt;
    logic [7:0]  ovf_per_tick;

    release_t    pending_q[$];
    int          errors;
    int          items_in;
    int          items_out;
    int          ticks_seen;
    int          idle_cycles;
    bit          hold_req;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic push_result(logic kind, logic [7:0] hd, logic [1:0] st, logic last);
        release_t r;
        r.kind = kind;
        r.handle = hd;
        r.status = st;
        r.last = last;
        pending_q.push_back(r);
    endtask

    // Advance the shadow scheduler by one accepted item
    task automatic schedule_item(t_func f, logic [7:0] hd, logic [15:0] per, logic [7:0] pr);
        bit due[SLOTS];
        bit found;
        int best;
        int n;
        case (f)
            FUNC_CREATE: begin
                if (fill_ptr < SLOTS) begin
                    tbl_valid[fill_ptr] = 1'b1;
                    tbl_handle[fill_ptr] = hd;
                    tbl_period[fill_ptr] = per;
                    tbl_prio[fill_ptr] = pr;
                    fill_ptr++;
                    push_result(KIND_STATUS, 8'd0, ST_DONE, 1'b1);
                end else begin
                    push_result(KIND_STATUS, 8'd0, ST_FULL, 1'b1);
                end
            end
            FUNC_DELETE: begin
                found = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_handle[i] == hd) begin
                        tbl_valid[i] = 1'b0;
                        tbl_handle[i] = '0;
                        tbl_period[i] = '0;
                        tbl_prio[i] = '0;
                        found = 1'b1;
                    end
                end
                push_result(KIND_STATUS, 8'd0, found ? ST_DONE : ST_NOT_FOUND, 1'b1);
            end
            FUNC_TICK: begin
                ovf_cnt = ovf_cnt + 8'd1;
                if (ovf_cnt >= ovf_per_tick) begin
                    ovf_cnt = '0;
                    tick_cnt = tick_cnt + 8'd1;
                    ticks_seen++;
                    for (int i = 0; i < SLOTS; i++)
                        due[i] = tbl_valid[i] && tbl_period[i] != 0
                                 && ({8'd0, tick_cnt} % tbl_period[i]) == 0;
                    n = 0;
                    // Pick due tasks in priority order, lower slot wins ties
                    while (n < RESULT_CAP) begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (due[i] && (best < 0 || tbl_prio[i] < tbl_prio[best]))
                                best = i;
                        if (best < 0)
                            break;
                        due[best] = 1'b0;
                        push_result(KIND_RELEASE, tbl_handle[best], ST_DONE, 1'b0);
                        n++;
                    end
                    if (n > 0)
                        pending_q[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one item after a random gap and wait for it to be taken
    task automatic send_item(t_func f, logic [7:0] hd, logic [15:0] per, logic [7:0] pr);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pr, per, hd};
        s_axis_tuser <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        items_in++;
        schedule_item(f, hd, per, pr);
    endtask

    // Let the block drain, then write the prescaler register
    task automatic set_prescale(logic [7:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_q.size() == 0);
        repeat (DRAIN_LEN) @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        ovf_per_tick = val;
    endtask

    task automatic random_phase(int count, bit with_hold);
        t_func       f;
        logic [7:0]  hd;
        logic [15:0] per;
        int          pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      f = FUNC_TICK;
            else if (pick < 75) f = FUNC_DELETE;
            else if (pick < 92) f = FUNC_CREATE;
            else                f = FUNC_NONE;
            hd = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(10, 16)) : 8'($urandom);
            per = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            if (with_hold && k == count / 2)
                hold_req = 1'b1;
            send_item(f, hd, per, 8'($urandom));
        end
    endtask

    // Sink results with random stalls and check them in order
    initial begin
        int stall;
        release_t want;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            items_out++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result, handle", m_axis_tdata[7:0], -1);
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tuser[0] !== want.kind)
                    report_mismatch("kind", m_axis_tuser[0], want.kind);
                if (m_axis_tdata[7:0] !== want.handle)
                    report_mismatch("released_handle", m_axis_tdata[7:0], want.handle);
                if (m_axis_tdata[9:8] !== want.status)
                    report_mismatch("status", m_axis_tdata[9:8], want.status);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results pending",
                     idle_cycles, pending_q.size());
            $display("periodic_task_release_scheduler_unit_test: FAIL");
            $finish;
        end
    end

    initial begin
        cmd_row_t dir_tab[$];
        int typed_st;
        errors = 0;
        items_in = 0;
        items_out = 0;
        ticks_seen = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        fill_ptr = 0;
        ovf_cnt = '0;
        tick_cnt = '0;
        ovf_per_tick = OPT_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_handle[i] = '0;
            tbl_period[i] = '0;
            tbl_prio[i] = '0;
        end

        // Empty table, handle zero, period zero, extremes, full table, ties
        dir_tab.push_back('{FUNC_DELETE, 8'd5,   16'd0,     8'd0,   1, ST_NOT_FOUND});
        dir_tab.push_back('{FUNC_CREATE, 8'd0,   16'd1,     8'd255, 1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd255, 16'd0,     8'd0,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd10,  16'd2,     8'd0,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd11,  16'd65535, 8'd7,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd12,  16'd1,     8'd7,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd13,  16'd4,     8'd7,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd14,  16'd1,     8'd3,   1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd15,  16'd3,     8'd128, 1, ST_DONE});
        dir_tab.push_back('{FUNC_CREATE, 8'd16,  16'd1,     8'd1,   1, ST_FULL});
        dir_tab.push_back('{FUNC_NONE,   8'd255, 16'd65535, 8'd255, 0, ST_DONE});
        for (int i = 0; i < 8; i++)
            dir_tab.push_back('{FUNC_TICK, 8'd0, 16'd0, 8'd0, 0, ST_DONE});
        dir_tab.push_back('{FUNC_DELETE, 8'd12,  16'd0,     8'd0,   1, ST_DONE});
        dir_tab.push_back('{FUNC_DELETE, 8'd12,  16'd0,     8'd0,   1, ST_NOT_FOUND});
        for (int i = 0; i < 4; i++)
            dir_tab.push_back('{FUNC_TICK, 8'd0, 16'd0, 8'd0, 0, ST_DONE});

        // Hold reset, then release it at a clock edge
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].f, dir_tab[i].hd, dir_tab[i].per, dir_tab[i].pr);
            if (dir_tab[i].typed) begin
                typed_st = pending_q.size() ? int'(pending_q[$].status) : -1;
                if (typed_st != int'(dir_tab[i].st))
                    report_mismatch("table row status", typed_st, dir_tab[i].st);
            end
        end

        // Random phases across prescaler settings, one with a long output stall
        set_prescale(8'd1);
        random_phase(90, 1'b1);
        set_prescale(8'd0);
        random_phase(80, 1'b0);
        set_prescale(8'd255);
        random_phase(40, 1'b0);
        set_prescale(8'($urandom_range(2, 6)));
        random_phase(80, 1'b0);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending_q.size() == 0);
        repeat (DRAIN_LEN) @(posedge i_clk);

        $display("covered %0d items in, %0d results out, %0d scheduler ticks",
                 items_in, items_out, ticks_seen);
        $display("prescaler settings 4, 1, 0, 255 and a random one; %0d mismatches", errors);
        if (errors == 0)
            $display("periodic_task_release_scheduler_unit_test: PASS");
        else
            $display("periodic_task_release_scheduler_unit_test: FAIL");
        $finish;
    end

endmodule
